// File: design/service_method_registry_defines.svh
// assertion macros for the checker file
`ifndef SERVICE_METHOD_REGISTRY_DEFINES_SVH
`define SERVICE_METHOD_REGISTRY_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SMR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("service_method_registry check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define SMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("service_method_registry check failed");

`endif

// File: design/smr_pkg.sv
`default_nettype none

package smr_pkg;

    localparam int SERVICE_SLOTS_DEF = 16;
    localparam int METHOD_SLOTS_DEF  = 16;
    localparam int ID_W              = 16;
    localparam int SLOT_OUT_W        = 4;

    // request kinds
    localparam logic [1:0] K_ADD_SVC = 2'd0;
    localparam logic [1:0] K_ADD_MTH = 2'd1;
    localparam logic [1:0] K_FIND    = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_NOSVC   = 3'd3;
    localparam logic [2:0] ST_HASMETH = 3'd4;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] svc_id;
        logic [ID_W-1:0] mth_id;
    } t_req;

    typedef struct packed {
        logic [2:0]            status;
        logic [SLOT_OUT_W-1:0] service_slot;
        logic [SLOT_OUT_W-1:0] method_slot;
        logic                  has_method;
    } t_rsp;

    // scan unit status toward the controller
    typedef struct packed {
        logic done;
        logic found;
    } t_scan_st;

endpackage

`default_nettype wire

// File: design/smr_ram.sv
`default_nettype none

module smr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/smr_scan.sv
`default_nettype none

// linear search of the filled part of one id table, one read per cycle
module smr_scan #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [CW-1:0]           i_fill,
    input  wire logic [smr_pkg::ID_W-1:0] i_key,
    output logic                         o_rd_en,
    output logic      [AW-1:0]           o_rd_addr,
    input  wire logic [smr_pkg::ID_W-1:0] i_rd_key,
    output smr_pkg::t_scan_st            o_st,
    output logic      [AW-1:0]           o_slot
);

    import smr_pkg::*;

    logic          r_busy;
    logic          r_rd_vld;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_cmp_idx;
    t_scan_st      r_st;
    logic [AW-1:0] r_slot;

    logic hit;
    logic more;

    assign hit       = r_rd_vld && (i_rd_key == i_key);
    assign more      = r_idx < i_fill;
    assign o_rd_en   = r_busy && more && !hit;
    assign o_rd_addr = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_st     <= '0;
        end else begin
            r_st.done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (r_busy) begin
                if (hit) begin
                    r_busy   <= 1'b0;
                    r_rd_vld <= 1'b0;
                    r_st     <= '{done: 1'b1, found: 1'b1};
                    r_slot   <= r_cmp_idx;
                end else if (!more && !r_rd_vld) begin
                    r_busy <= 1'b0;
                    r_st   <= '{done: 1'b1, found: 1'b0};
                    r_slot <= '0;
                end else begin
                    r_rd_vld <= o_rd_en;
                    if (o_rd_en) begin
                        r_idx     <= r_idx + CW'(1);
                        r_cmp_idx <= r_idx[AW-1:0];
                    end
                end
            end
        end
    end

    assign o_st   = r_st;
    assign o_slot = r_slot;

endmodule

`default_nettype wire

// File: design/service_method_registry.sv
// service and method registry, fill-only
//
// input channel  i_in_valid / o_in_ready, item i_in_data (kind, svc_id, mth_id)
// output channel o_out_valid / i_out_ready, item o_out_data
//   (status, service_slot, method_slot, has_method); exactly one result per request
//
// one request is worked at a time. the service table and the method table each sit in
// a synchronous ram and are searched linearly, one entry per cycle, up to the fill count.
// the time from accept to result valid grows with the fill counts searched:
//   add service / find     a search of the service table
//   add method             a service table search, then at most a method table search
//   table full or bad kind no search
// the search loops set the rate.
// o_in_ready rises again the cycle after the result is loaded into the output register,
// so a new item may be taken while the previous result still waits.
// if the receiver stalls, the finished result waits in the controller until the output
// register frees up; nothing is lost.
// reset (synchronous, active low) empties both tables (fill counts and link bits cleared);
// no sweep of the rams is needed and the block is ready the cycle after reset.
`default_nettype none

module service_method_registry #(
    parameter int SERVICE_SLOTS = smr_pkg::SERVICE_SLOTS_DEF,
    parameter int METHOD_SLOTS  = smr_pkg::METHOD_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire smr_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output smr_pkg::t_rsp      o_out_data
);

    import smr_pkg::*;

    // service slot and fill widths
    localparam int SAW = (SERVICE_SLOTS > 1) ? $clog2(SERVICE_SLOTS) : 1;
    localparam int SCW = $clog2(SERVICE_SLOTS + 1);
    // method slot and fill widths
    localparam int MAW = (METHOD_SLOTS > 1) ? $clog2(METHOD_SLOTS) : 1;
    localparam int MCW = $clog2(METHOD_SLOTS + 1);
    // service entry: linked method slot above the service id
    localparam int SVC_W = ID_W + MAW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SVC,
        S_MTH,
        S_DONE
    } t_state;

    function automatic t_rsp mk_rsp(input logic [2:0] st,
                                    input logic [SLOT_OUT_W-1:0] ss,
                                    input logic [SLOT_OUT_W-1:0] ms,
                                    input logic hm);
        t_rsp r;
        r.status       = st;
        r.service_slot = ss;
        r.method_slot  = ms;
        r.has_method   = hm;
        return r;
    endfunction

    t_state             r_state;
    t_req               r_req;
    logic [SCW-1:0]     r_svc_fill;
    logic [MCW-1:0]     r_mth_fill;
    logic [SERVICE_SLOTS-1:0] r_linked;
    logic [SAW-1:0]     r_svc_slot;
    t_rsp               r_rsp;
    logic               r_out_valid;
    t_rsp               r_out;
    logic               r_svc_start;
    logic               r_mth_start;

    // registered ram writes
    logic               r_svc_we;
    logic [SAW-1:0]     r_svc_waddr;
    logic [SVC_W-1:0]   r_svc_wdata;
    logic               r_mth_we;
    logic [MAW-1:0]     r_mth_waddr;
    logic [ID_W-1:0]    r_mth_wdata;

    // ram read side
    logic               svc_re;
    logic [SAW-1:0]     svc_raddr;
    logic [SVC_W-1:0]   svc_rdata;
    logic               mth_re;
    logic [MAW-1:0]     mth_raddr;
    logic [ID_W-1:0]    mth_rdata;

    // scan results
    t_scan_st           svc_st;
    logic [SAW-1:0]     svc_slot;
    t_scan_st           mth_st;
    logic [MAW-1:0]     mth_slot_unused;

    // slot values widened so that their low four bits can be reported
    logic [SAW+SLOT_OUT_W-1:0] found_slot_w;
    logic [SAW+SLOT_OUT_W-1:0] new_svc_slot_w;
    logic [SAW+SLOT_OUT_W-1:0] held_svc_slot_w;
    logic [MAW+SLOT_OUT_W-1:0] new_mth_slot_w;
    logic [MAW+SLOT_OUT_W-1:0] link_slot_w;

    logic in_acc;
    logic svc_full;
    logic mth_full;

    assign found_slot_w    = {{SLOT_OUT_W{1'b0}}, svc_slot};
    assign new_svc_slot_w  = {{SLOT_OUT_W{1'b0}}, r_svc_fill[SAW-1:0]};
    assign held_svc_slot_w = {{SLOT_OUT_W{1'b0}}, r_svc_slot};
    assign new_mth_slot_w  = {{SLOT_OUT_W{1'b0}}, r_mth_fill[MAW-1:0]};
    // after a hit the ram output still holds the matching entry
    assign link_slot_w     = {{SLOT_OUT_W{1'b0}}, svc_rdata[ID_W +: MAW]};

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign svc_full   = r_svc_fill >= SCW'(SERVICE_SLOTS);
    assign mth_full   = r_mth_fill >= MCW'(METHOD_SLOTS);

    // service table: id in the low bits, linked method slot above
    smr_ram #(
        .WIDTH (SVC_W),
        .DEPTH (SERVICE_SLOTS)
    ) u_svc_ram (
        .i_clk   (i_clk),
        .i_we    (r_svc_we),
        .i_waddr (r_svc_waddr),
        .i_wdata (r_svc_wdata),
        .i_re    (svc_re),
        .i_raddr (svc_raddr),
        .o_rdata (svc_rdata)
    );

    smr_ram #(
        .WIDTH (ID_W),
        .DEPTH (METHOD_SLOTS)
    ) u_mth_ram (
        .i_clk   (i_clk),
        .i_we    (r_mth_we),
        .i_waddr (r_mth_waddr),
        .i_wdata (r_mth_wdata),
        .i_re    (mth_re),
        .i_raddr (mth_raddr),
        .o_rdata (mth_rdata)
    );

    // service id search
    smr_scan #(
        .DEPTH (SERVICE_SLOTS)
    ) u_svc_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_svc_start),
        .i_fill    (r_svc_fill),
        .i_key     (r_req.svc_id),
        .o_rd_en   (svc_re),
        .o_rd_addr (svc_raddr),
        .i_rd_key  (svc_rdata[ID_W-1:0]),
        .o_st      (svc_st),
        .o_slot    (svc_slot)
    );

    // method id uniqueness search; only found/not found matters here
    smr_scan #(
        .DEPTH (METHOD_SLOTS)
    ) u_mth_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mth_start),
        .i_fill    (r_mth_fill),
        .i_key     (r_req.mth_id),
        .o_rd_en   (mth_re),
        .o_rd_addr (mth_raddr),
        .i_rd_key  (mth_rdata),
        .o_st      (mth_st),
        .o_slot    (mth_slot_unused)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_svc_fill  <= '0;
            r_mth_fill  <= '0;
            r_linked    <= '0;
            r_out_valid <= 1'b0;
            r_svc_start <= 1'b0;
            r_mth_start <= 1'b0;
            r_svc_we    <= 1'b0;
            r_mth_we    <= 1'b0;
        end else begin
            // single-cycle pulses
            r_svc_start <= 1'b0;
            r_mth_start <= 1'b0;
            r_svc_we    <= 1'b0;
            r_mth_we    <= 1'b0;
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req <= i_in_data;
                        case (i_in_data.kind)
                            K_ADD_SVC: begin
                                if (svc_full) begin
                                    r_rsp   <= mk_rsp(ST_FULL, '0, '0, 1'b0);
                                    r_state <= S_DONE;
                                end else begin
                                    r_svc_start <= 1'b1;
                                    r_state     <= S_SVC;
                                end
                            end
                            K_ADD_MTH: begin
                                // method table full is checked before anything else
                                if (mth_full) begin
                                    r_rsp   <= mk_rsp(ST_FULL, '0, '0, 1'b0);
                                    r_state <= S_DONE;
                                end else begin
                                    r_svc_start <= 1'b1;
                                    r_state     <= S_SVC;
                                end
                            end
                            K_FIND: begin
                                r_svc_start <= 1'b1;
                                r_state     <= S_SVC;
                            end
                            default: begin
                                // unused kind answers as an unknown service
                                r_rsp   <= mk_rsp(ST_NOSVC, '0, '0, 1'b0);
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_SVC: begin
                    if (svc_st.done) begin
                        r_state <= S_DONE;
                        case (r_req.kind)
                            K_ADD_SVC: begin
                                if (svc_st.found) begin
                                    r_rsp <= mk_rsp(ST_DUP, '0, '0, 1'b0);
                                end else begin
                                    // append at the fill point, link starts empty
                                    r_svc_we    <= 1'b1;
                                    r_svc_waddr <= r_svc_fill[SAW-1:0];
                                    r_svc_wdata <= {{MAW{1'b0}}, r_req.svc_id};
                                    r_linked[r_svc_fill[SAW-1:0]] <= 1'b0;
                                    r_svc_fill  <= r_svc_fill + SCW'(1);
                                    r_rsp <= mk_rsp(ST_OK, new_svc_slot_w[SLOT_OUT_W-1:0],
                                                    '0, 1'b0);
                                end
                            end
                            K_ADD_MTH: begin
                                if (!svc_st.found) begin
                                    r_rsp <= mk_rsp(ST_NOSVC, '0, '0, 1'b0);
                                end else if (r_linked[svc_slot]) begin
                                    r_rsp <= mk_rsp(ST_HASMETH, '0, '0, 1'b0);
                                end else begin
                                    r_svc_slot  <= svc_slot;
                                    r_mth_start <= 1'b1;
                                    r_state     <= S_MTH;
                                end
                            end
                            K_FIND: begin
                                if (!svc_st.found) begin
                                    r_rsp <= mk_rsp(ST_NOSVC, '0, '0, 1'b0);
                                end else if (r_linked[svc_slot]) begin
                                    r_rsp <= mk_rsp(ST_OK, found_slot_w[SLOT_OUT_W-1:0],
                                                    link_slot_w[SLOT_OUT_W-1:0], 1'b1);
                                end else begin
                                    r_rsp <= mk_rsp(ST_OK, found_slot_w[SLOT_OUT_W-1:0],
                                                    '0, 1'b0);
                                end
                            end
                            default: begin
                                r_rsp <= mk_rsp(ST_NOSVC, '0, '0, 1'b0);
                            end
                        endcase
                    end
                end

                S_MTH: begin
                    if (mth_st.done) begin
                        r_state <= S_DONE;
                        if (mth_st.found) begin
                            r_rsp <= mk_rsp(ST_DUP, '0, '0, 1'b0);
                        end else begin
                            // store the method and link it to the service entry
                            r_mth_we    <= 1'b1;
                            r_mth_waddr <= r_mth_fill[MAW-1:0];
                            r_mth_wdata <= r_req.mth_id;
                            r_svc_we    <= 1'b1;
                            r_svc_waddr <= r_svc_slot;
                            r_svc_wdata <= {r_mth_fill[MAW-1:0], r_req.svc_id};
                            r_linked[r_svc_slot] <= 1'b1;
                            r_mth_fill  <= r_mth_fill + MCW'(1);
                            r_rsp <= mk_rsp(ST_OK, held_svc_slot_w[SLOT_OUT_W-1:0],
                                            new_mth_slot_w[SLOT_OUT_W-1:0], 1'b1);
                        end
                    end
                end

                S_DONE: begin
                    // hand the result over once the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_rsp;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: design/smr_checker.sv
`default_nettype none
`include "service_method_registry_defines.svh"

module smr_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire smr_pkg::t_req i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire smr_pkg::t_rsp o_out_data
);

    import smr_pkg::*;

    logic in_acc;
    logic rsp_err;
    logic rsp_bare;
    logic rsp_clear;

    assign in_acc    = i_in_valid && o_in_ready;
    assign rsp_err   = o_out_valid && (o_out_data.status != ST_OK);
    assign rsp_bare  = o_out_valid && !o_out_data.has_method;
    assign rsp_clear = (o_out_data.service_slot == '0) && (o_out_data.method_slot == '0)
                       && !o_out_data.has_method;

    // a stalled result holds
    `SMR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // any failed request reports empty slot fields
    `SMR_ASSERT_NOW(a_err_zero, rsp_err, rsp_clear)

    // no linked method means no method slot
    `SMR_ASSERT_NOW(a_nolink_zero, rsp_bare, o_out_data.method_slot == '0)

    // one request at a time: busy right after an accept
    `SMR_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_in_ready)

endmodule

bind service_method_registry smr_checker u_smr_checker (.*);

`default_nettype wire
